>>> rtl/afu_pkg.sv
// Shared types, constants and table builder for the activation function unit.
// Used by the interfaces and by every module of the unit; depends on nothing.
package afu_pkg;

   localparam int DATA_W    = 24;
   localparam int FRAC_BITS = 16;
   localparam int QI        = 30;
   localparam int Q_W       = QI + 1;
   localparam int EXP_STEPS = FRAC_BITS + 5;
   localparam int TAB_OFS   = 24;
   localparam int TAB_BASE  = TAB_OFS - FRAC_BITS;
   localparam int DIV_N_W   = 2 * QI + 1;
   localparam int DIV_D_W   = QI + 2;
   localparam int VAL_W     = 58;

   localparam logic [Q_W-1:0] ONE_I  = Q_W'(1) << QI;
   localparam logic [Q_W-1:0] HALF_I = Q_W'(1) << (QI - 1);

   // ELU uses alpha = 0.1, applied as a rounded division by ten.
   localparam logic [DIV_D_W-1:0] ELU_DIV  = DIV_D_W'(10);
   localparam logic [DIV_N_W-1:0] ELU_HALF = DIV_N_W'(5);

   typedef enum logic [3:0] {
      FN_SWISH, FN_SWISH_D, FN_RELU, FN_RELU_D, FN_LEAKY, FN_LEAKY_D,
      FN_TANH, FN_TANH_D, FN_SIGMOID, FN_SIGMOID_D, FN_SOFTSIGN, FN_SOFTSIGN_D,
      FN_ELU, FN_ELU_D, FN_PASS, FN_PASS_ALT
   } afu_func_type;

   localparam afu_func_type FN_RESET = FN_RELU;

   typedef enum logic [1:0] {RND_NONE, RND_HALF, RND_FRAC, RND_FULL} afu_rnd_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      afu_func_type             fsel;
   } afu_ctx_type;

   // Q30 value of e^-(2^(idx-TAB_OFS)), built from an alternating series for the
   // small arguments and by repeated squaring above e^-1. Elaboration only.
   function automatic logic [63:0] exp_tab_value(input int idx);
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] prev;
      logic        done;
      int          k;
      term = 64'd1 << 62;
      sum  = term;
      done = 1'b0;
      k    = TAB_OFS - idx;
      if (idx <= TAB_OFS) begin
         for (int n = 1; n < 24; n++) begin
            if (!done) begin
               term = (term >> k) / 64'(n);
               if (term == 64'd0) done = 1'b1;
               else if (n[0]) sum = sum - term;
               else sum = sum + term;
            end
         end
         prev = (sum + (64'd1 << 31)) >> 32;
      end else begin
         prev = exp_tab_value(idx - 1);
         prev = (prev * prev + 64'(HALF_I)) >> QI;
      end
      return prev;
   endfunction

endpackage

>>> rtl/afu_if.sv
// Request and response channel interfaces of the activation function unit.
// Depends on afu_pkg for the sample width.
interface afu_req_if
   import afu_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface afu_rsp_if
   import afu_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample_out;
   logic                     saturated;
   modport source (output valid, output sample_out, output saturated, input ready);
   modport sink (input valid, input sample_out, input saturated, output ready);
endinterface

>>> rtl/afu_exp.sv
// Pipelined e^-a: one stage per bit of a, each a rounded Q30 multiply by a
// constant table entry. Depends on afu_pkg.
module afu_exp
   import afu_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [EXP_STEPS-1:0] in_a,
   input  logic                 in_zero,
   input  afu_ctx_type          in_ctx,
   output logic                 out_valid,
   output logic [Q_W-1:0]       out_u,
   output afu_ctx_type          out_ctx
);

   logic                 vld_ff  [EXP_STEPS];
   logic [Q_W-1:0]       r_ff    [EXP_STEPS];
   logic [EXP_STEPS-1:0] a_ff    [EXP_STEPS];
   logic                 zero_ff [EXP_STEPS];
   afu_ctx_type          ctx_ff  [EXP_STEPS];

   logic                 vld_src  [EXP_STEPS+1];
   logic [Q_W-1:0]       r_src    [EXP_STEPS+1];
   logic [EXP_STEPS-1:0] a_src    [EXP_STEPS+1];
   logic                 zero_src [EXP_STEPS+1];
   afu_ctx_type          ctx_src  [EXP_STEPS+1];

   assign vld_src[0]  = in_valid;
   assign r_src[0]    = ONE_I;
   assign a_src[0]    = in_a;
   assign zero_src[0] = in_zero;
   assign ctx_src[0]  = in_ctx;

   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_step
      localparam logic [Q_W-1:0] TAB = Q_W'(exp_tab_value(i + TAB_BASE));
      logic [2*Q_W-1:0] prod;
      logic [Q_W-1:0]   r_in;

      assign prod = (2*Q_W)'(r_src[i]) * (2*Q_W)'(TAB);
      assign r_in = a_src[i][i] ? Q_W'((prod + (2*Q_W)'(HALF_I)) >> QI) : r_src[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_src[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            r_ff[i]    <= r_in;
            a_ff[i]    <= a_src[i];
            zero_ff[i] <= zero_src[i];
            ctx_ff[i]  <= ctx_src[i];
         end
      end

      assign vld_src[i+1]  = vld_ff[i];
      assign r_src[i+1]    = r_ff[i];
      assign a_src[i+1]    = a_ff[i];
      assign zero_src[i+1] = zero_ff[i];
      assign ctx_src[i+1]  = ctx_ff[i];
   end

   assign out_valid = vld_src[EXP_STEPS];
   assign out_u     = zero_src[EXP_STEPS] ? '0 : r_src[EXP_STEPS];
   assign out_ctx   = ctx_src[EXP_STEPS];

endmodule

>>> rtl/afu_div.sv
// Pipelined restoring divider, one quotient bit per stage. The numerator must
// be below the divisor times 2^Q_W. Depends on afu_pkg.
module afu_div
   import afu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [DIV_N_W-1:0] in_n,
   input  logic [DIV_D_W-1:0] in_d,
   input  afu_ctx_type        in_ctx,
   output logic               out_valid,
   output logic [Q_W-1:0]     out_q,
   output afu_ctx_type        out_ctx
);

   localparam int STEPS = Q_W;

   logic               vld_ff [STEPS];
   logic [DIV_D_W-1:0] rem_ff [STEPS];
   logic [Q_W-1:0]     quo_ff [STEPS];
   logic [STEPS-1:0]   low_ff [STEPS];
   logic [DIV_D_W-1:0] d_ff   [STEPS];
   afu_ctx_type        ctx_ff [STEPS];

   logic               vld_src [STEPS+1];
   logic [DIV_D_W-1:0] rem_src [STEPS+1];
   logic [Q_W-1:0]     quo_src [STEPS+1];
   logic [STEPS-1:0]   low_src [STEPS+1];
   logic [DIV_D_W-1:0] d_src   [STEPS+1];
   afu_ctx_type        ctx_src [STEPS+1];

   assign vld_src[0] = in_valid;
   assign rem_src[0] = DIV_D_W'(in_n[DIV_N_W-1:STEPS]);
   assign quo_src[0] = '0;
   assign low_src[0] = in_n[STEPS-1:0];
   assign d_src[0]   = in_d;
   assign ctx_src[0] = in_ctx;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [DIV_D_W:0]   trial;
      logic               fits;
      logic [DIV_D_W-1:0] rem_in;

      assign trial  = {rem_src[j], low_src[j][STEPS-1-j]};
      assign fits   = trial >= {1'b0, d_src[j]};
      assign rem_in = fits ? DIV_D_W'(trial - {1'b0, d_src[j]}) : DIV_D_W'(trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_src[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= {quo_src[j][Q_W-2:0], fits};
            low_ff[j] <= low_src[j];
            d_ff[j]   <= d_src[j];
            ctx_ff[j] <= ctx_src[j];
         end
      end

      assign vld_src[j+1] = vld_ff[j];
      assign rem_src[j+1] = rem_ff[j];
      assign quo_src[j+1] = quo_ff[j];
      assign low_src[j+1] = low_ff[j];
      assign d_src[j+1]   = d_ff[j];
      assign ctx_src[j+1] = ctx_ff[j];
   end

   assign out_valid = vld_src[STEPS];
   assign out_q     = quo_src[STEPS];
   assign out_ctx   = ctx_src[STEPS];

endmodule

>>> rtl/afu_post.sv
// Finishing stages: logistic symmetry, slope and product multiplies, selection
// per function, rounding, sign and saturation into the output register.
// Depends on afu_pkg.
module afu_post
   import afu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic [Q_W-1:0]           in_q,
   input  afu_ctx_type              in_ctx,
   output logic                     out_valid,
   output logic signed [DATA_W-1:0] out_sample,
   output logic                     out_saturated
);

   localparam int PW = 56;
   localparam int FR = QI - FRAC_BITS;
   localparam logic signed [VAL_W-1:0] ONE_V  = VAL_W'(1) << FRAC_BITS;
   localparam logic signed [VAL_W-1:0] HALF_V = VAL_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [VAL_W:0]   SAT_HI = (VAL_W+1)'((1 << (DATA_W - 1)) - 1);
   localparam logic signed [VAL_W:0]   SAT_LO = -((VAL_W+1)'(1) << (DATA_W - 1));

   logic              vld_ff [1:7];
   afu_ctx_type       ctx_ff [1:6];

   logic [Q_W-1:0]        p1_s_ff, p2_s_ff, p3_s_ff, p4_s_ff;
   logic [2*Q_W-1:0]      p2_prod_ff;
   logic signed [PW-1:0]  p2_px_ff, p3_px_ff, p4_px_ff;
   logic [Q_W-1:0]        p3_sl_ff, p4_sl_ff;
   logic signed [PW-1:0]  p4_py_ff;
   logic signed [VAL_W-1:0] p5_val_ff;
   afu_rnd_type           p5_rnd_ff;
   logic                  p5_neg_ff;
   logic [VAL_W-1:0]      p6_mag_ff;
   logic                  p6_sign_ff;
   logic signed [DATA_W-1:0] p7_sample_ff;
   logic                  p7_sat_ff;

   logic [Q_W-1:0]          s_in, b_in;
   logic signed [VAL_W-1:0] val_in;
   afu_rnd_type             rnd_in;
   logic                    neg_in;
   logic [VAL_W-1:0]        abs_in, mag_in;
   logic signed [VAL_W:0]   r_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= 7; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[1] <= in_valid;
         for (int k = 2; k <= 7; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   // Stage 1: the logistic of a negative input is one minus that of |x|.
   always_comb begin
      s_in = in_q;
      if ((in_ctx.fsel == FN_SWISH || in_ctx.fsel == FN_SWISH_D ||
           in_ctx.fsel == FN_SIGMOID || in_ctx.fsel == FN_SIGMOID_D) && in_ctx.x < 0)
         s_in = ONE_I - in_q;
   end

   assign b_in = (ctx_ff[1].fsel == FN_SOFTSIGN_D) ? p1_s_ff : ONE_I - p1_s_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[1] <= in_ctx;
         for (int k = 2; k <= 6; k++) ctx_ff[k] <= ctx_ff[k-1];
         p1_s_ff    <= s_in;
         p2_s_ff    <= p1_s_ff;
         p2_prod_ff <= (2*Q_W)'(p1_s_ff) * (2*Q_W)'(b_in);
         p2_px_ff   <= PW'(ctx_ff[1].x) * PW'($signed({1'b0, p1_s_ff}));
         p3_s_ff    <= p2_s_ff;
         p3_px_ff   <= p2_px_ff;
         p3_sl_ff   <= Q_W'((p2_prod_ff + (2*Q_W)'(HALF_I)) >> QI);
         p4_s_ff    <= p3_s_ff;
         p4_px_ff   <= p3_px_ff;
         p4_sl_ff   <= p3_sl_ff;
         p4_py_ff   <= PW'(ctx_ff[3].x) * PW'($signed({1'b0, p3_sl_ff}));
         p5_val_ff  <= val_in;
         p5_rnd_ff  <= rnd_in;
         p5_neg_ff  <= neg_in;
         p6_mag_ff  <= mag_in;
         p6_sign_ff <= p5_val_ff[VAL_W-1] ^ p5_neg_ff;
      end
   end

   // Stage 5: pick the value, the rounding and the sign for each function.
   always_comb begin
      val_in = VAL_W'(ctx_ff[4].x);
      rnd_in = RND_NONE;
      neg_in = 1'b0;
      unique case (ctx_ff[4].fsel)
         FN_SWISH: begin
            val_in = VAL_W'(p4_px_ff);
            rnd_in = RND_FULL;
         end
         FN_SWISH_D: begin
            val_in = $signed(VAL_W'({p4_s_ff, {FRAC_BITS{1'b0}}})) + VAL_W'(p4_py_ff);
            rnd_in = RND_FULL;
         end
         FN_RELU: val_in = (ctx_ff[4].x > 0) ? VAL_W'(ctx_ff[4].x) : '0;
         FN_RELU_D: val_in = (ctx_ff[4].x >= 0) ? ONE_V : '0;
         FN_LEAKY: rnd_in = (ctx_ff[4].x < 0) ? RND_HALF : RND_NONE;
         FN_LEAKY_D: val_in = (ctx_ff[4].x >= 0) ? ONE_V : HALF_V;
         FN_TANH: begin
            val_in = $signed(VAL_W'({p4_s_ff, 1'b0})) - $signed(VAL_W'(ONE_I));
            rnd_in = RND_FRAC;
            neg_in = ctx_ff[4].x < 0;
         end
         FN_TANH_D: begin
            val_in = $signed(VAL_W'({p4_sl_ff, 2'b00}));
            rnd_in = RND_FRAC;
         end
         FN_SIGMOID: begin
            val_in = $signed(VAL_W'(p4_s_ff));
            rnd_in = RND_FRAC;
         end
         FN_SIGMOID_D, FN_SOFTSIGN_D: begin
            val_in = $signed(VAL_W'(p4_sl_ff));
            rnd_in = RND_FRAC;
         end
         FN_SOFTSIGN: begin
            val_in = $signed(VAL_W'(p4_s_ff));
            neg_in = ctx_ff[4].x < 0;
         end
         FN_ELU: begin
            if (ctx_ff[4].x < 0) begin
               val_in = $signed(VAL_W'(p4_s_ff));
               rnd_in = RND_FRAC;
               neg_in = 1'b1;
            end
         end
         FN_ELU_D: begin
            if (ctx_ff[4].x < 0) begin
               val_in = $signed(VAL_W'(p4_s_ff));
               rnd_in = RND_FRAC;
            end else begin
               val_in = ONE_V;
            end
         end
         FN_PASS, FN_PASS_ALT: val_in = VAL_W'(ctx_ff[4].x);
      endcase
   end

   // Stage 6: round the magnitude half up, which is half away from zero overall.
   assign abs_in = p5_val_ff[VAL_W-1] ? VAL_W'(-p5_val_ff) : VAL_W'(p5_val_ff);

   always_comb begin
      unique case (p5_rnd_ff)
         RND_NONE: mag_in = abs_in;
         RND_HALF: mag_in = (abs_in + VAL_W'(1)) >> 1;
         RND_FRAC: mag_in = (abs_in + (VAL_W'(1) << (FR - 1))) >> FR;
         RND_FULL: mag_in = (abs_in + (VAL_W'(1) << (QI - 1))) >> QI;
      endcase
   end

   // Stage 7: apply the sign and clip to the output range.
   assign r_in = p6_sign_ff ? -$signed({1'b0, p6_mag_ff}) : $signed({1'b0, p6_mag_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         if (r_in > SAT_HI) begin
            p7_sample_ff <= DATA_W'(SAT_HI);
            p7_sat_ff    <= 1'b1;
         end else if (r_in < SAT_LO) begin
            p7_sample_ff <= DATA_W'(SAT_LO);
            p7_sat_ff    <= 1'b1;
         end else begin
            p7_sample_ff <= DATA_W'(r_in);
            p7_sat_ff    <= 1'b0;
         end
      end
   end

   assign out_valid     = vld_ff[7];
   assign out_sample    = p7_sample_ff;
   assign out_saturated = p7_sat_ff;

endmodule

>>> rtl/activation_function_unit_core.sv
// Activation function unit: top level with input stage, divider setup stage
// and configuration register. Depends on afu_pkg, afu_if, afu_exp, afu_div, afu_post.
//
// Usage: samples (signed Q7.16) arrive on req_if and results leave on rsp_if,
// both valid/ready channels; a transfer happens when valid and ready are high.
// The function is chosen by the function_select register at APB address 0
// (writes at address 4 are ignored); each sample carries the code that was
// set when it was taken, so the register should be written while the unit is
// empty. pready is always high.
// The path from the input transfer to rsp_if.valid runs through one input
// stage, 21 exponent stages (one table multiply per bit of the argument), one
// divider setup stage, 31 divider stages (one quotient bit each) and 7
// finishing stages. One sample is taken every cycle while results drain.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// req_if.ready drops in the same cycle; nothing is lost or repeated.
// Reset empties the pipeline and sets function_select to ReLU.
module activation_function_unit_core
   import afu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   afu_req_if.sink           req_if,
   afu_rsp_if.source         rsp_if,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam logic                 CSR_IDX_FSEL = 1'b0;
   localparam logic [DATA_W:0]      EXP_LIMIT    = (DATA_W+1)'(32) << FRAC_BITS;
   localparam logic [DIV_N_W-1:0]   LOGI_NUM     = DIV_N_W'(1) << (2 * QI);
   localparam logic [DIV_N_W-1:0]   RECIP_NUM    = DIV_N_W'(1) << (QI + FRAC_BITS);
   localparam logic [DIV_D_W-1:0]   ONE_Q        = DIV_D_W'(1) << FRAC_BITS;

   afu_func_type fsel_ff;
   logic         adv;
   logic         csr_wr;

   logic                 s0_vld_ff;
   afu_ctx_type          s0_ctx_ff;
   logic [EXP_STEPS-1:0] s0_a_ff;
   logic                 s0_zero_ff;
   logic [DATA_W-1:0]    in_mag;
   logic [DATA_W:0]      in_a;

   logic           ex_vld;
   logic [Q_W-1:0] ex_u;
   afu_ctx_type    ex_ctx;

   logic               dp_vld_ff;
   logic [DIV_N_W-1:0] dp_n_ff, n_in;
   logic [DIV_D_W-1:0] dp_d_ff, d_in;
   afu_ctx_type        dp_ctx_ff;
   logic [DATA_W-1:0]  ex_mag;

   logic           dv_vld;
   logic [Q_W-1:0] dv_q;
   afu_ctx_type    dv_ctx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_FSEL) ? 32'(fsel_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff <= FN_RESET;
      end else if (csr_wr && csr_paddr[2] == CSR_IDX_FSEL) begin
         fsel_ff <= afu_func_type'(csr_pwdata[3:0]);
      end
   end

   // The pipeline moves as a whole unless a result waits in the output register.
   assign adv          = !rsp_if.valid || rsp_if.ready;
   assign req_if.ready = adv;

   assign in_mag = req_if.sample_in[DATA_W-1] ? DATA_W'(-req_if.sample_in)
                                              : DATA_W'(req_if.sample_in);
   assign in_a   = (fsel_ff == FN_TANH || fsel_ff == FN_TANH_D) ? {in_mag, 1'b0}
                                                                : {1'b0, in_mag};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         dp_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_if.valid;
         dp_vld_ff <= ex_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ctx_ff  <= '{x: req_if.sample_in, fsel: fsel_ff};
         s0_a_ff    <= in_a[EXP_STEPS-1:0];
         s0_zero_ff <= in_a >= EXP_LIMIT;
         dp_n_ff    <= n_in;
         dp_d_ff    <= d_in;
         dp_ctx_ff  <= ex_ctx;
      end
   end

   afu_exp u_exp (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_vld_ff),
      .in_a      (s0_a_ff),
      .in_zero   (s0_zero_ff),
      .in_ctx    (s0_ctx_ff),
      .out_valid (ex_vld),
      .out_u     (ex_u),
      .out_ctx   (ex_ctx)
   );

   // Divider operands; every quotient is rounded by adding half the divisor.
   assign ex_mag = ex_ctx.x[DATA_W-1] ? DATA_W'(-ex_ctx.x) : DATA_W'(ex_ctx.x);

   always_comb begin
      d_in = DIV_D_W'(1);
      n_in = '0;
      unique case (ex_ctx.fsel)
         FN_SWISH, FN_SWISH_D, FN_TANH, FN_TANH_D, FN_SIGMOID, FN_SIGMOID_D: begin
            d_in = DIV_D_W'(ONE_I) + DIV_D_W'(ex_u);
            n_in = LOGI_NUM + DIV_N_W'(d_in >> 1);
         end
         FN_SOFTSIGN: begin
            d_in = ONE_Q + DIV_D_W'(ex_mag);
            n_in = (DIV_N_W'(ex_mag) << FRAC_BITS) + DIV_N_W'(d_in >> 1);
         end
         FN_SOFTSIGN_D: begin
            d_in = ONE_Q + DIV_D_W'(ex_mag);
            n_in = RECIP_NUM + DIV_N_W'(d_in >> 1);
         end
         FN_ELU: begin
            d_in = ELU_DIV;
            n_in = DIV_N_W'(ONE_I) - DIV_N_W'(ex_u) + ELU_HALF;
         end
         FN_ELU_D: begin
            d_in = ELU_DIV;
            n_in = DIV_N_W'(ex_u) + ELU_HALF;
         end
         FN_RELU, FN_RELU_D, FN_LEAKY, FN_LEAKY_D, FN_PASS, FN_PASS_ALT: begin
            d_in = DIV_D_W'(1);
            n_in = '0;
         end
      endcase
   end

   afu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dp_vld_ff),
      .in_n      (dp_n_ff),
      .in_d      (dp_d_ff),
      .in_ctx    (dp_ctx_ff),
      .out_valid (dv_vld),
      .out_q     (dv_q),
      .out_ctx   (dv_ctx)
   );

   afu_post u_post (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (dv_vld),
      .in_q          (dv_q),
      .in_ctx        (dv_ctx),
      .out_valid     (rsp_if.valid),
      .out_sample    (rsp_if.sample_out),
      .out_saturated (rsp_if.saturated)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_if.valid)
      else $error("result valid right after reset");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.saturated |->
         (rsp_if.sample_out == DATA_W'((1 << (DATA_W - 1)) - 1) ||
          rsp_if.sample_out == DATA_W'(1 << (DATA_W - 1))))
      else $error("saturation flag without a clipped result");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_paddr[2] == CSR_IDX_FSEL |=> fsel_ff == $past(csr_pwdata[3:0]))
      else $error("function select not updated by write");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid)
      else $error("result dropped while receiver stalled");

endmodule
